FILE: rtl/swt_pkg.sv
package swt_pkg;

  // result kinds
  localparam logic [2:0] K_ARGCH   = 3'd0;
  localparam logic [2:0] K_FLAGCH  = 3'd1;
  localparam logic [2:0] K_ARGEND  = 3'd2;
  localparam logic [2:0] K_LINEEND = 3'd3;
  localparam logic [2:0] K_ERROR   = 3'd4;

  // error codes
  localparam logic [1:0] E_UNKNOWN   = 2'd0;
  localparam logic [1:0] E_QUOTE     = 2'd1;
  localparam logic [1:0] E_BACKSLASH = 2'd2;

  // characters with a role in the grammar
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_TILDE      = 8'h7E;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_BSLASH     = 8'h5C;
  localparam logic [7:0] CH_DOLLAR     = 8'h24;

  // output word layout
  localparam int OUT_TDATA_W = 16;

  // default depth of the queue between front and back
  localparam int SWT_FIFO_DEPTH = 4;

  // one result word
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [1:0] err;
    logic       last;
  } swt_res_t;

  // all results of one input byte
  typedef struct packed {
    logic     two;
    swt_res_t r0;
    swt_res_t r1;
  } swt_entry_t;

endpackage

FILE: rtl/swt_front.sv
module swt_front
  import swt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       q_full,
  output logic       q_push,
  output swt_entry_t q_entry
);

  // tokenizer modes
  localparam logic [2:0] M_BETWEEN = 3'd0;
  localparam logic [2:0] M_ARG     = 3'd1;
  localparam logic [2:0] M_SQUOTE  = 3'd2;
  localparam logic [2:0] M_DQUOTE  = 3'd3;
  localparam logic [2:0] M_DQ_BS   = 3'd4;
  localparam logic [2:0] M_BS      = 3'd5;
  localparam logic [2:0] M_FLAGS   = 3'd6;
  localparam logic [2:0] M_DISCARD = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic       has;
    swt_res_t   res;
  } btw_t;

  logic [2:0] mode_r, mode_nxt;
  logic       prev_ws_r, prev_ws_nxt;
  logic       first_r, first_nxt;
  logic       accept;
  logic [7:0] b;
  logic [1:0] n;
  swt_res_t   r0, r1;
  btw_t       bt;

  function automatic swt_res_t mk_res(input logic [2:0] kind, input logic [7:0] data,
                                      input logic [1:0] err);
    swt_res_t r;
    r.kind = kind;
    r.data = data;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alnum(c) || (c inside {CH_UNDERSCORE, CH_DOT, CH_SLASH, CH_DASH, CH_TILDE});
  endfunction

  // handling of a byte between tokens
  function automatic btw_t between_f(input logic [7:0] c, input logic pws, input logic first);
    btw_t o;
    o.mode = M_BETWEEN;
    o.has  = 1'b0;
    o.res  = mk_res(K_ARGCH, CH_NUL, E_UNKNOWN);
    if (c == CH_NUL) begin
      o.has = 1'b1;
      o.res = mk_res(K_LINEEND, CH_NUL, E_UNKNOWN);
    end else if (is_ws(c)) begin
      o.mode = M_BETWEEN;
    end else if (c == CH_DASH && pws && !first) begin
      o.mode = M_FLAGS;
    end else if (c == CH_SQUOTE) begin
      o.mode = M_SQUOTE;
    end else if (c == CH_DQUOTE) begin
      o.mode = M_DQUOTE;
    end else if (c == CH_BSLASH) begin
      o.mode = M_BS;
    end else if (is_word(c)) begin
      o.mode = M_ARG;
      o.has  = 1'b1;
      o.res  = mk_res(K_ARGCH, c, E_UNKNOWN);
    end else begin
      o.mode = M_DISCARD;
      o.has  = 1'b1;
      o.res  = mk_res(K_ERROR, CH_NUL, E_UNKNOWN);
    end
    return o;
  endfunction

  assign b         = in_tdata;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // next mode and the results of this byte
  always_comb begin
    mode_nxt = mode_r;
    n        = 2'd0;
    r0       = mk_res(K_ARGCH, CH_NUL, E_UNKNOWN);
    r1       = mk_res(K_ARGCH, CH_NUL, E_UNKNOWN);
    bt       = between_f(b, prev_ws_r, first_r);
    case (mode_r)
      M_BETWEEN: begin
        mode_nxt = bt.mode;
        r0       = bt.res;
        n        = {1'b0, bt.has};
      end
      M_ARG: begin
        if (b == CH_SQUOTE) begin
          mode_nxt = M_SQUOTE;
        end else if (b == CH_DQUOTE) begin
          mode_nxt = M_DQUOTE;
        end else if (b == CH_BSLASH) begin
          mode_nxt = M_BS;
        end else if (is_word(b)) begin
          r0 = mk_res(K_ARGCH, b, E_UNKNOWN);
          n  = 2'd1;
        end else begin
          // argument ends, byte handled as between tokens
          bt       = between_f(b, 1'b0, first_r);
          r0       = mk_res(K_ARGEND, CH_NUL, E_UNKNOWN);
          r1       = bt.res;
          n        = bt.has ? 2'd2 : 2'd1;
          mode_nxt = bt.mode;
        end
      end
      M_SQUOTE: begin
        if (b == CH_SQUOTE) begin
          mode_nxt = M_ARG;
        end else if (b == CH_NUL) begin
          r0       = mk_res(K_ERROR, CH_NUL, E_QUOTE);
          n        = 2'd1;
          mode_nxt = M_DISCARD;
        end else begin
          r0 = mk_res(K_ARGCH, b, E_UNKNOWN);
          n  = 2'd1;
        end
      end
      M_DQUOTE: begin
        if (b == CH_DQUOTE) begin
          mode_nxt = M_ARG;
        end else if (b == CH_NUL) begin
          r0       = mk_res(K_ERROR, CH_NUL, E_QUOTE);
          n        = 2'd1;
          mode_nxt = M_DISCARD;
        end else if (b == CH_BSLASH) begin
          mode_nxt = M_DQ_BS;
        end else begin
          r0 = mk_res(K_ARGCH, b, E_UNKNOWN);
          n  = 2'd1;
        end
      end
      M_DQ_BS: begin
        if (b inside {CH_BSLASH, CH_DOLLAR, CH_DQUOTE}) begin
          r0       = mk_res(K_ARGCH, b, E_UNKNOWN);
          n        = 2'd1;
          mode_nxt = M_DQUOTE;
        end else begin
          // held backslash goes out, then the byte inside double quotes, or a quote error on the terminator
          r0 = mk_res(K_ARGCH, CH_BSLASH, E_UNKNOWN);
          n  = 2'd1;
          if (b == CH_NUL) begin
            r1       = mk_res(K_ERROR, CH_NUL, E_QUOTE);
            n        = 2'd2;
            mode_nxt = M_DISCARD;
          end else begin
            r1       = mk_res(K_ARGCH, b, E_UNKNOWN);
            n        = 2'd2;
            mode_nxt = M_DQUOTE;
          end
        end
      end
      M_BS: begin
        if (b == CH_NUL) begin
          r0       = mk_res(K_ERROR, CH_NUL, E_BACKSLASH);
          n        = 2'd1;
          mode_nxt = M_DISCARD;
        end else begin
          r0       = mk_res(K_ARGCH, b, E_UNKNOWN);
          n        = 2'd1;
          mode_nxt = M_ARG;
        end
      end
      M_FLAGS: begin
        if (is_alnum(b)) begin
          r0 = mk_res(K_FLAGCH, b, E_UNKNOWN);
          n  = 2'd1;
        end else begin
          bt       = between_f(b, 1'b0, first_r);
          r0       = bt.res;
          n        = {1'b0, bt.has};
          mode_nxt = bt.mode;
        end
      end
      default: begin
        mode_nxt = M_DISCARD;
      end
    endcase
    // terminator restarts the line
    if (b == CH_NUL) begin
      mode_nxt    = M_BETWEEN;
      prev_ws_nxt = 1'b0;
      first_nxt   = 1'b1;
    end else begin
      prev_ws_nxt = is_ws(b);
      first_nxt   = 1'b0;
    end
  end

  // queue entry
  always_comb begin
    q_entry.two     = (n == 2'd2);
    q_entry.r0      = r0;
    q_entry.r0.last = (n == 2'd1);
    q_entry.r1      = r1;
    q_entry.r1.last = 1'b1;
  end

  assign q_push = accept && (n != 2'd0);

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_BETWEEN;
      prev_ws_r <= 1'b0;
      first_r   <= 1'b1;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      prev_ws_r <= prev_ws_nxt;
      first_r   <= first_nxt;
    end
  end

endmodule

FILE: rtl/swt_fifo.sv
module swt_fifo
  import swt_pkg::*;
#(
  parameter int DEPTH = SWT_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  swt_entry_t push_entry,
  input  logic       pop,
  output swt_entry_t head,
  output logic       full,
  output logic       empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  swt_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/swt_back.sv
module swt_back
  import swt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  swt_entry_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output swt_res_t   out_res
);

  logic     out_valid_r, out_valid_nxt;
  swt_res_t out_res_r, out_res_nxt;
  logic     sel_r, sel_nxt;
  logic     load;

  assign load = !out_valid_r || out_ready;

  // unpack one or two results per entry into the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    sel_nxt       = sel_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        if (sel_r) begin
          out_res_nxt = q_head.r1;
          q_pop       = 1'b1;
          sel_nxt     = 1'b0;
        end else begin
          out_res_nxt = q_head.r0;
          q_pop       = !q_head.two;
          sel_nxt     = q_head.two;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: rtl/shell_word_tokenizer.sv
// channel | direction | tdata                            | tuser   | tlast
// in_     | slave     | [7:0] byte_req                   | -       | -
// out_    | master    | [7:0] out_byte, [9:8] error_code | kind    | last
//
// one input byte is taken per cycle while the result queue has room
// each byte gives zero, one or two result words; the output register sends one per cycle
// while out_tready is high, so a byte with two results goes out as two words
// a stalled output fills the queue (FIFO_DEPTH entries) before in_tready drops
// rst_n is synchronous and active low; it returns the tokenizer to the start of a line
module shell_word_tokenizer
  import swt_pkg::*;
#(
  parameter int FIFO_DEPTH = SWT_FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] byte_req
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [9:8] error_code
  output logic [2:0]             out_tuser,  // [2:0] kind
  output logic                   out_tlast   // last word of the input byte
);

  logic       q_full, q_empty, q_push, q_pop;
  swt_entry_t q_entry, q_head;
  swt_res_t   res;

  // classify bytes and track the line
  swt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // result queue
  swt_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // output stage
  swt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {(OUT_TDATA_W - 10)'(0), res.err, res.data};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

FILE: rtl/swt_checker.sv
module swt_checker
  import swt_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]             out_tuser,
  input logic                   out_tlast
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output word changed while stalled");

  // error code only on error words
  a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != K_ERROR |-> out_tdata[9:8] == 2'd0)
    else $error("error code on a non-error word");

  // no character on end and error words
  a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == K_ARGEND || out_tuser == K_LINEEND || out_tuser == K_ERROR)
      |-> out_tdata[7:0] == 8'd0)
    else $error("character on an end or error word");

  // line end and error close the results of their byte
  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == K_LINEEND || out_tuser == K_ERROR) |-> out_tlast)
    else $error("line end or error not marked last");

endmodule

bind shell_word_tokenizer swt_checker u_swt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
